// ===== hdl/olis_pkg.sv =====
// Shared types and constants for the ordered list insert store.
package olis_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 32;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_FRONT  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_POS    = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

endpackage

// ===== hdl/olis_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts or rotates with its neighbors.
module olis_cell #(
    parameter int CNT_W = 6
) (
    input  logic                                i_clk,
    input  olis_pkg::t_cell_op                  i_op,
    input  logic [CNT_W-1:0]                    i_index,
    input  logic [CNT_W-1:0]                    i_ins_idx,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_new_value,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_prev_value,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_next_value,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_wrap_value,
    output logic signed [olis_pkg::DATA_W-1:0]  o_value
);
    import olis_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic [CNT_W-1:0]         w_index_p1;

    assign w_index_p1 = i_index + CNT_W'(1);

    // Select the next content of this cell
    always_comb begin
        n_value = r_value;
        case (i_op)
            CELL_INSERT: begin
                if (i_index == i_ins_idx) begin
                    n_value = i_new_value;
                end else if (i_index > i_ins_idx) begin
                    n_value = i_prev_value;
                end
            end
            CELL_ROTATE: begin
                // last live cell takes the front entry, others pull from behind
                if (w_index_p1 == i_count) begin
                    n_value = i_wrap_value;
                end else begin
                    n_value = i_next_value;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== hdl/olis_ctrl.sv =====
// Command sequencer: entry count, readout walk and the result register.
module olis_ctrl #(
    parameter int CAPACITY = olis_pkg::DEF_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [olis_pkg::CMD_W-1:0]          i_command,
    input  logic [olis_pkg::POS_W-1:0]          i_target_position,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_front_value,
    output olis_pkg::t_cell_op                  o_op,
    output logic [CNT_W-1:0]                    o_ins_idx,
    output logic [CNT_W-1:0]                    o_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [olis_pkg::STATUS_W-1:0]       o_status,
    output logic signed [olis_pkg::DATA_W-1:0]  o_entry_value,
    output logic                                o_is_entry,
    output logic                                o_last
);
    import olis_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_rd_cnt, n_rd_cnt;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic                     r_is_entry, n_is_entry;
    logic                     r_last, n_last;

    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_bad_pos;
    logic                     w_rd_last;
    logic [CMP_W-1:0]         w_pos_ext;
    logic [CMP_W-1:0]         w_count_ext;
    logic [CNT_W-1:0]         w_rd_cnt_p1;
    t_cmd                     w_cmd;

    // Handshake helpers
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_valid && !o_stall;
    assign w_cmd       = t_cmd'(i_command);
    assign w_pos_ext   = CMP_W'(i_target_position);
    assign w_count_ext = CMP_W'(r_count);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_bad_pos   = (w_pos_ext > w_count_ext);
    assign w_rd_cnt_p1 = r_rd_cnt + CNT_W'(1);
    assign w_rd_last   = (w_rd_cnt_p1 == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_cmd == CMD_READ) && (r_count != '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_out_free && w_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: chain operation, count update and result load
    always_comb begin
        o_op        = CELL_HOLD;
        o_ins_idx   = '0;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_entry     = r_entry;
        n_is_entry  = r_is_entry;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                n_rd_cnt = '0;
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_entry     = '0;
                    n_is_entry  = 1'b0;
                    n_last      = 1'b1;
                    n_status    = ST_OK;
                    if (w_cmd == CMD_READ) begin
                        // nonempty list: the walk produces the results instead
                        n_out_valid = (r_count == '0);
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else if ((w_cmd == CMD_POS) && w_bad_pos) begin
                        n_status = ST_BADPOS;
                    end else begin
                        o_op    = CELL_INSERT;
                        n_count = r_count + CNT_W'(1);
                        case (w_cmd)
                            CMD_FRONT:  o_ins_idx = '0;
                            CMD_APPEND: o_ins_idx = r_count;
                            default:    o_ins_idx = w_pos_ext[CNT_W-1:0];
                        endcase
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    // emit the front entry and rotate the chain by one
                    o_op        = CELL_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_entry     = i_front_value;
                    n_is_entry  = 1'b1;
                    n_last      = w_rd_last;
                    n_rd_cnt    = w_rd_cnt_p1;
                end
            end
            default: o_op = CELL_HOLD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_entry    <= n_entry;
        r_is_entry <= n_is_entry;
        r_last     <= n_last;
    end

    assign o_count       = r_count;
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_entry;
    assign o_is_entry    = r_is_entry;
    assign o_last        = r_last;

endmodule

// ===== hdl/ordered_list_insert_store.sv =====
// Top level of the ordered list store: sequencer plus a chain of entry cells.
//
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_command, i_item_value, i_target_position
//  output    o_valid   i_stall   o_status, o_entry_value, o_is_entry, o_last
//
// An insert writes the item at its index as the cells above shift in parallel; the
// status result is registered for the next cycle; inserts go back to back unless stalled.
// A readout of N entries rotates the chain one place per cycle while the result is not
// stalled, the front cell feeding the result register; input is stalled meanwhile.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// A stalled result holds the result register and, in turn, stalls the input.
module ordered_list_insert_store #(
    parameter int CAPACITY = olis_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [olis_pkg::CMD_W-1:0]          i_command,
    input  logic signed [olis_pkg::DATA_W-1:0]  i_item_value,
    input  logic [olis_pkg::POS_W-1:0]          i_target_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [olis_pkg::STATUS_W-1:0]       o_status,
    output logic signed [olis_pkg::DATA_W-1:0]  o_entry_value,
    output logic                                o_is_entry,
    output logic                                o_last
);
    import olis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_cell_op                 w_op;
    logic [CNT_W-1:0]         w_ins_idx;
    logic [CNT_W-1:0]         w_count;
    logic signed [DATA_W-1:0] w_cell_q [CAPACITY];

    // Sequencer
    olis_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_target_position (i_target_position),
        .i_front_value     (w_cell_q[0]),
        .o_op              (w_op),
        .o_ins_idx         (w_ins_idx),
        .o_count           (w_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_entry_value     (o_entry_value),
        .o_is_entry        (o_is_entry),
        .o_last            (o_last)
    );

    // Chain of entry cells, index 0 at the front
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (g == 0) begin : g_head
            assign w_prev = w_cell_q[g];
        end else begin : g_body
            assign w_prev = w_cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = w_cell_q[g];
        end else begin : g_inner
            assign w_next = w_cell_q[g+1];
        end

        olis_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_index      (CNT_W'(g)),
            .i_ins_idx    (w_ins_idx),
            .i_count      (w_count),
            .i_new_value  (i_item_value),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .i_wrap_value (w_cell_q[0]),
            .o_value      (w_cell_q[g])
        );
    end

endmodule
